// ===== hw/rtl/fpa_pkg.sv =====
// fpa_pkg: command codes and pipeline sideband type for the fixed-point alu
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CMD_W  = 4;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_MIN      = 4'd4,
        CMD_MAX      = 4'd5,
        CMD_INC      = 4'd6,
        CMD_DEC      = 4'd7,
        CMD_FROM_INT = 4'd8,
        CMD_TO_INT   = 4'd9
    } t_cmd;

    // sideband that travels beside the divider data
    typedef struct packed {
        logic              is_div;
        logic              neg;
        logic              dz;
        logic [DATA_W-1:0] simple;
        logic              lt;
        logic              eq;
        logic              gt;
    } t_meta;

endpackage

// ===== hw/rtl/fixed_point_alu.sv =====
// fixed_point_alu: pipelined signed fixed-point alu with bit-per-stage divider
// default FRACTION_BITS = 8 gives Q24.8; requests pass front register, divider stages, output register
// throughput: one request per cycle unless the output stalls; every command runs the full pipeline
// depth set by the divider, one quotient bit per stage over 32 + FRACTION_BITS stages
// the whole pipeline holds when the output request is not taken
// reset: synchronous active-low, clears valid bits only
`timescale 1ns / 1ps
module fixed_point_alu #(
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // command[3:0], operand_a[35:4], operand_b[67:36], zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata   // result[31:0], a_less, a_equal, a_greater, divide_by_zero, zero
);
    import fpa_pkg::*;

    localparam int unsigned DW = DATA_W + FRACTION_BITS;

    logic              w_en;
    logic              w_valid [0:DW];
    t_meta             w_meta  [0:DW];
    logic [DATA_W-1:0] w_rem   [0:DW];
    logic [DW-1:0]     w_dq    [0:DW];
    logic [DATA_W-1:0] w_div   [0:DW];
    logic              r_out_valid;
    logic [DATA_W-1:0] r_result;
    logic              r_lt;
    logic              r_eq;
    logic              r_gt;
    logic              r_dz;
    logic [DATA_W-1:0] n_result;
    logic [DATA_W-1:0] w_q;

    // global advance when output slot is free or being taken
    assign w_en       = ~r_out_valid | i_m_tready;
    assign o_s_tready = w_en;

    fpa_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_cmd   (i_s_tdata[3:0]),
        .i_a     (i_s_tdata[35:4]),
        .i_b     (i_s_tdata[67:36]),
        .o_valid (w_valid[0]),
        .o_meta  (w_meta[0]),
        .o_rem   (w_rem[0]),
        .o_dq    (w_dq[0]),
        .o_div   (w_div[0])
    );

    // divider stages
    for (genvar k = 0; k < DW; k++) begin : g_div
        fpa_div_stage #(
            .DW(DW)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_meta  (w_meta[k]),
            .i_rem   (w_rem[k]),
            .i_dq    (w_dq[k]),
            .i_div   (w_div[k]),
            .o_valid (w_valid[k+1]),
            .o_meta  (w_meta[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_dq    (w_dq[k+1]),
            .o_div   (w_div[k+1])
        );
    end

    // final select and quotient sign fix
    assign w_q = w_dq[DW][DATA_W-1:0];
    always_comb begin
        if (!w_meta[DW].is_div) begin
            n_result = w_meta[DW].simple;
        end else if (w_meta[DW].dz) begin
            n_result = '0;
        end else if (w_meta[DW].neg) begin
            n_result = DATA_W'(0) - w_q;
        end else begin
            n_result = w_q;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid[DW];
        end
        if (w_en) begin
            r_result <= n_result;
            r_lt     <= w_meta[DW].lt;
            r_eq     <= w_meta[DW].eq;
            r_gt     <= w_meta[DW].gt;
            r_dz     <= w_meta[DW].dz;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_dz, r_gt, r_eq, r_lt, r_result};

`ifndef SYNTH
    // a zero divisor always gives a zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[35] |-> o_m_tdata[31:0] == '0)
        else $error("divide by zero result not zero");

    // exactly one compare flag per result
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $onehot(o_m_tdata[34:32]))
        else $error("compare flags not one-hot");

    // input side follows output slot state
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("ready does not match output slot");

    // a held result keeps its value until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("pending result changed");
`endif

endmodule

// ===== hw/rtl/fpa_front.sv =====
// fpa_front: decode, simple results, product and divider setup register stage
`timescale 1ns / 1ps
module fpa_front #(
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [fpa_pkg::CMD_W-1:0]          i_cmd,
    input  logic [fpa_pkg::DATA_W-1:0]         i_a,
    input  logic [fpa_pkg::DATA_W-1:0]         i_b,
    output logic                               o_valid,
    output fpa_pkg::t_meta                     o_meta,
    output logic [fpa_pkg::DATA_W-1:0]         o_rem,
    output logic [fpa_pkg::DATA_W+FRACTION_BITS-1:0] o_dq,
    output logic [fpa_pkg::DATA_W-1:0]         o_div
);
    import fpa_pkg::*;

    localparam int unsigned DW = DATA_W + FRACTION_BITS;

    logic                     r_valid;
    t_meta                    r_meta;
    logic [DATA_W-1:0]        r_div;
    logic [DW-1:0]            r_dq;
    t_meta                    n_meta;
    logic signed [DATA_W-1:0] w_sa;
    logic signed [DATA_W-1:0] w_sb;
    logic signed [2*DATA_W-1:0] w_prod;
    logic [DATA_W-1:0]        w_ma;
    logic [DATA_W-1:0]        w_mb;
    t_cmd                     w_cmd;

    assign w_sa   = i_a;
    assign w_sb   = i_b;
    assign w_cmd  = t_cmd'(i_cmd);
    assign w_prod = w_sa * w_sb;
    assign w_ma   = i_a[DATA_W-1] ? (DATA_W'(0) - i_a) : i_a;
    assign w_mb   = i_b[DATA_W-1] ? (DATA_W'(0) - i_b) : i_b;

    // decode and simple results
    always_comb begin
        n_meta        = '0;
        n_meta.lt     = w_sa < w_sb;
        n_meta.eq     = i_a == i_b;
        n_meta.gt     = w_sa > w_sb;
        n_meta.is_div = w_cmd == CMD_DIV;
        n_meta.dz     = (w_cmd == CMD_DIV) && (i_b == '0);
        n_meta.neg    = i_a[DATA_W-1] ^ i_b[DATA_W-1];
        unique case (w_cmd)
            CMD_ADD:      n_meta.simple = i_a + i_b;
            CMD_SUB:      n_meta.simple = i_a - i_b;
            CMD_MUL:      n_meta.simple = DATA_W'(w_prod >>> FRACTION_BITS);
            CMD_MIN:      n_meta.simple = (w_sa < w_sb) ? i_a : i_b;
            CMD_MAX:      n_meta.simple = (w_sa > w_sb) ? i_a : i_b;
            CMD_INC:      n_meta.simple = i_a + DATA_W'(1);
            CMD_DEC:      n_meta.simple = i_a - DATA_W'(1);
            CMD_FROM_INT: n_meta.simple = i_a << FRACTION_BITS;
            CMD_TO_INT:   n_meta.simple = DATA_W'(w_sa >>> FRACTION_BITS);
            default:      n_meta.simple = '0;
        endcase
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_meta <= n_meta;
            r_div  <= w_mb;
            r_dq   <= DW'(w_ma) << FRACTION_BITS;
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_rem   = '0;
    assign o_dq    = r_dq;
    assign o_div   = r_div;

endmodule

// ===== hw/rtl/fpa_div_stage.sv =====
// fpa_div_stage: one restoring division step, one quotient bit per stage
`timescale 1ns / 1ps
module fpa_div_stage #(
    parameter int unsigned DW = 40
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  fpa_pkg::t_meta             i_meta,
    input  logic [fpa_pkg::DATA_W-1:0] i_rem,
    input  logic [DW-1:0]              i_dq,
    input  logic [fpa_pkg::DATA_W-1:0] i_div,
    output logic                       o_valid,
    output fpa_pkg::t_meta             o_meta,
    output logic [fpa_pkg::DATA_W-1:0] o_rem,
    output logic [DW-1:0]              o_dq,
    output logic [fpa_pkg::DATA_W-1:0] o_div
);
    import fpa_pkg::*;

    logic              r_valid;
    t_meta             r_meta;
    logic [DATA_W-1:0] r_rem;
    logic [DW-1:0]     r_dq;
    logic [DATA_W-1:0] r_div;
    logic [DATA_W:0]   w_trial;
    logic [DATA_W:0]   w_diff;
    logic              w_ge;

    // shift in next dividend bit and try the subtract
    assign w_trial = {i_rem, i_dq[DW-1]};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign w_ge    = ~w_diff[DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_meta <= i_meta;
            r_div  <= i_div;
            r_rem  <= w_ge ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
            r_dq   <= {i_dq[DW-2:0], w_ge};
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;
    assign o_div   = r_div;

endmodule
